>>> rtl/hff_pkg.sv
// ----------------------------------------------------------------------------
// hff_pkg
// Shared types and constants of the hydraulic friction coefficient block.
// ----------------------------------------------------------------------------
package hff_pkg;

  localparam int MAX_ITER_DEF  = 50;
  localparam int FRAC_BITS_DEF = 32;

  // Roughness laws carried in the input tuser
  localparam logic [1:0] ACT_COLEBROOK = 2'd0;
  localparam logic [1:0] ACT_NIKURADSE = 2'd1;
  localparam logic [1:0] ACT_MANNING   = 2'd2;
  localparam logic [1:0] ACT_CHEZY     = 2'd3;

  // Result status carried in the output tuser
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FALLBACK = 2'd1;
  localparam logic [1:0] ST_INVALID  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_VON_KARMAN = 2'd0;
  localparam logic [1:0] REG_VISCOSITY  = 2'd1;
  localparam logic [1:0] REG_GRAVITY    = 2'd2;

  localparam logic [47:0] VON_KARMAN_RST = 48'd1760936591;
  localparam logic [47:0] VISCOSITY_RST  = 48'd4295;
  localparam logic [47:0] GRAVITY_RST    = 48'd42133629174;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic         start;
    logic [127:0] num;
    logic [127:0] den;
    logic [6:0]   shift;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic        sat;
    logic [63:0] q;
  } div_rsp_t;

endpackage

>>> rtl/hff_mul.sv
// ----------------------------------------------------------------------------
// hff_mul
// Shared 64 x 64 multiplier built from four 32 x 32 partial products.
// ----------------------------------------------------------------------------
module hff_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  hff_pkg::mul_req_t req,
  output hff_pkg::mul_rsp_t rsp
);
  import hff_pkg::*;

  logic [63:0]  a_r, b_r;
  logic [127:0] acc_r;
  logic [63:0]  prod_r;
  logic [2:0]   step_r;
  logic         busy_r, done_r;
  logic [1:0]   prev;
  logic [1:0]   sh_units;
  logic [31:0]  op_a, op_b;

  assign op_a     = step_r[1] ? a_r[63:32] : a_r[31:0];
  assign op_b     = step_r[0] ? b_r[63:32] : b_r[31:0];
  assign prev     = step_r[1:0] - 2'd1;
  assign sh_units = {1'b0, prev[1]} + {1'b0, prev[0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 3'd1;
        if (step_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req.a;
      b_r   <= req.b;
      acc_r <= '0;
    end else if (busy_r) begin
      if (step_r != 3'd4) begin
        prod_r <= op_a * op_b;
      end
      if (step_r != 3'd0) begin
        acc_r <= acc_r + ({64'b0, prod_r} << {sh_units, 5'b0});
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.p    = acc_r;

endmodule

>>> rtl/hff_div.sv
// ----------------------------------------------------------------------------
// hff_div
// Shared restoring divider, one quotient bit a cycle, saturating to 64 bits.
// ----------------------------------------------------------------------------
module hff_div (
  input  logic              clk,
  input  logic              rst_n,
  input  hff_pkg::div_req_t req,
  output hff_pkg::div_rsp_t rsp
);
  import hff_pkg::*;

  logic [127:0] n_r, d_r, r_r;
  logic [63:0]  q_r;
  logic         sat_r, busy_r, done_r;
  logic [7:0]   cnt_r, last_r;
  logic [127:0] r_sh;
  logic         take;

  assign r_sh = {r_r[126:0], n_r[127]};
  assign take = r_r[127] || (r_sh >= d_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        if (req.den == '0) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r && cnt_r == last_r) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      n_r    <= req.num;
      d_r    <= req.den;
      r_r    <= '0;
      q_r    <= '0;
      sat_r  <= (req.den == '0);
      cnt_r  <= '0;
      last_r <= 8'd127 + {1'b0, req.shift};
    end else if (busy_r) begin
      n_r   <= {n_r[126:0], 1'b0};
      cnt_r <= cnt_r + 8'd1;
      if (q_r[63]) begin
        sat_r <= 1'b1;
      end
      if (take) begin
        r_r <= r_sh - d_r;
        q_r <= {q_r[62:0], 1'b1};
      end else begin
        r_r <= r_sh;
        q_r <= {q_r[62:0], 1'b0};
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.sat  = sat_r;
  assign rsp.q    = sat_r ? '1 : q_r;

endmodule

>>> rtl/hydraulic_friction_factor.sv
// ----------------------------------------------------------------------------
// hydraulic_friction_factor
// Friction coefficient after Colebrook-White, Nikuradse, Manning or Chezy.
// ----------------------------------------------------------------------------
// Each request on the in_ channel carries a roughness law in in_tuser and the
// roughness, flow speed and depth in in_tdata; one result leaves on the out_
// channel with the coefficient in out_tdata and a status in out_tuser. The
// cfg_ channel writes von Karman constant, viscosity and gravity, and is
// always ready; write it only while the block is idle.
// Requests are worked on one at a time by a sequencer driving one shared
// 64 x 64 multiplier and one shared bit-serial divider. A logarithm takes
// 32 squarings on the multiplier. Manning takes a cube root of 43 bits,
// three products a bit, and Colebrook-White iterates up to MAX_ITERATIONS
// passes. The division by 100 in each pass is a multiplication by a
// reciprocal.
// in_tready is high only while the sequencer is idle. The result is held in
// an output register, so a stalled receiver does not stop the next request
// from being taken; only its completion waits for the register to empty.
// Synchronous reset empties the output, idles the sequencer and restores the
// configuration registers to their defaults.
// ----------------------------------------------------------------------------
module hydraulic_friction_factor #(
  parameter int MAX_ITERATIONS = hff_pkg::MAX_ITER_DEF,
  parameter int FRACTION_BITS  = hff_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [143:0]  in_tdata,   // roughness [47:0], speed [95:48], depth [143:96]
  input  logic [1:0]    in_tuser,   // action [1:0]
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [47:0]   out_tdata,  // coefficient [47:0]
  output logic [1:0]    out_tuser,  // status [1:0]
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [47:0]   cfg_data
);
  import hff_pkg::*;

  // Alignment of external fixed point to the internal 32 fraction bits.
  localparam int SH_R   = (FRACTION_BITS >= 32) ? FRACTION_BITS - 32 : 0;
  localparam int SH_L   = (FRACTION_BITS < 32) ? 32 - FRACTION_BITS : 0;
  localparam int PASS_W = $clog2(MAX_ITERATIONS + 1);

  localparam logic [63:0] RE_HIGH   = 64'd500 << 32;
  localparam logic [63:0] RE_LOW    = 64'd100 << 32;
  localparam logic [63:0] POINT08   = 64'd343597384;
  localparam logic [63:0] LN2_Q32   = 64'd2977044472;
  localparam logic [63:0] CW_SLOPE  = 64'd262461539158;  // 2.03 * log10(2), scaled by 100
  // Ceiling of 2^51 / 100: the product shifted down by 51 is the exact floor
  // of a quotient by 100 for every dividend below 2^44.
  localparam logic [63:0] CS_RECIP  = 64'd22517998136853;
  localparam logic [63:0] X_START   = 64'd5 << 31;
  localparam logic [63:0] CONV_TOL  = 64'd1000000;

  typedef enum logic [43:0] {
    S_IDLE    = 44'd1 << 0,
    S_DISP    = 44'd1 << 1,
    S_WMUL    = 44'd1 << 2,
    S_WDIV    = 44'd1 << 3,
    S_LG_NORM = 44'd1 << 4,
    S_LG_SQ   = 44'd1 << 5,
    S_LG_SQ2  = 44'd1 << 6,
    S_CS1     = 44'd1 << 7,
    S_CS2     = 44'd1 << 8,
    S_CS3     = 44'd1 << 9,
    S_CZ1     = 44'd1 << 10,
    S_CZ2     = 44'd1 << 11,
    S_CB0     = 44'd1 << 12,
    S_CB1     = 44'd1 << 13,
    S_CB2     = 44'd1 << 14,
    S_CB3     = 44'd1 << 15,
    S_MN1     = 44'd1 << 16,
    S_MN2     = 44'd1 << 17,
    S_MN3     = 44'd1 << 18,
    S_MN4     = 44'd1 << 19,
    S_NK1     = 44'd1 << 20,
    S_NK2     = 44'd1 << 21,
    S_NK3     = 44'd1 << 22,
    S_NK4     = 44'd1 << 23,
    S_NK5     = 44'd1 << 24,
    S_NK6     = 44'd1 << 25,
    S_CW1     = 44'd1 << 26,
    S_CW2     = 44'd1 << 27,
    S_CW3     = 44'd1 << 28,
    S_LAM     = 44'd1 << 29,
    S_CW4     = 44'd1 << 30,
    S_CW5     = 44'd1 << 31,
    S_CW6     = 44'd1 << 32,
    S_CW7     = 44'd1 << 33,
    S_CW8     = 44'd1 << 34,
    S_IT      = 44'd1 << 35,
    S_IT1     = 44'd1 << 36,
    S_IT2     = 44'd1 << 37,
    S_IT3     = 44'd1 << 38,
    S_FB2     = 44'd1 << 39,
    S_FINX    = 44'd1 << 40,
    S_F1      = 44'd1 << 41,
    S_F2      = 44'd1 << 42,
    S_DONE    = 44'd1 << 43
  } state_t;

  function automatic logic [63:0] to_int(input logic [47:0] v);
    return ({16'b0, v} >> SH_R) << SH_L;
  endfunction

  function automatic mul_req_t mreq(input logic [63:0] a, input logic [63:0] b);
    mul_req_t m;
    m.start = 1'b1;
    m.a     = a;
    m.b     = b;
    return m;
  endfunction

  function automatic div_req_t dreq(input logic [127:0] n, input logic [127:0] d,
                                    input logic [6:0] sh);
    div_req_t r;
    r.start = 1'b1;
    r.num   = n;
    r.den   = d;
    r.shift = sh;
    return r;
  endfunction

  // Configuration registers
  logic [47:0] kappa_r, visc_r, grav_r;

  // Sequencer and datapath registers
  state_t        state_r, state_nxt, ret_r, ret_nxt;
  state_t        lg_ret_r, lg_ret_nxt, cs_ret_r, cs_ret_nxt;
  mul_req_t      mul_r, mul_nxt;
  div_req_t      div_r, div_nxt;
  mul_rsp_t      mul_rsp;
  div_rsp_t      div_rsp;
  logic [1:0]    act_r, act_nxt;
  logic [63:0]   k_r, k_nxt, u_r, u_nxt, h_r, h_nxt;
  logic [1:0]    st_r, st_nxt;
  logic          sat_r, sat_nxt;
  logic [63:0]   res_r, res_nxt;
  logic [63:0]   x_r, x_nxt, t1_r, t1_nxt, t2_r, t2_nxt, re_r, re_nxt;
  logic [127:0]  w_r, w_nxt;
  logic [PASS_W-1:0] pass_r, pass_nxt;
  logic [127:0]  lg_n_r, lg_n_nxt;
  logic [6:0]    lg_lz_r, lg_lz_nxt, lg_e_r, lg_e_nxt;
  logic [63:0]   lg_m_r, lg_m_nxt;
  logic [31:0]   lg_f_r, lg_f_nxt;
  logic [4:0]    lg_i_r, lg_i_nxt;
  logic [63:0]   cb_root_r, cb_root_nxt, cb_c2hi_r, cb_c2hi_nxt;
  logic [127:0]  cb_lo_r, cb_lo_nxt;
  logic [5:0]    cb_b_r, cb_b_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [47:0]   out_data_r, out_data_nxt;
  logic [1:0]    out_st_r, out_st_nxt;

  // Combinational helpers
  logic [63:0]  vk_int, g_int, ka_int;
  logic [63:0]  lg_res, lg_sq, cs_neg, cs_q, cb_c, cb_hi, nk_diff, it_a, it_d;
  logic         cb_ok;
  logic [127:0] it_arg;
  logic [63:0]  fmt_r2;
  logic         fmt_bad;

  assign vk_int  = to_int(visc_r);
  assign g_int   = to_int(grav_r);
  assign ka_int  = to_int(kappa_r);
  assign lg_res  = {25'b0, lg_e_r, lg_f_r};
  assign lg_sq   = mul_rsp.p[125:62];
  assign cs_neg  = (64'd64 << 32) - lg_res;
  assign cs_q    = mul_rsp.p[114:51];
  assign cb_c    = cb_root_r | (64'd1 << cb_b_r);
  assign cb_hi   = cb_lo_r[127:64] + mul_rsp.p[63:0];
  assign cb_ok   = (mul_rsp.p[127:64] == '0) && (cb_hi >= cb_lo_r[127:64]) &&
                   ({h_r, 64'b0} >= {cb_hi, cb_lo_r[63:0]});
  assign nk_diff = (t2_r > lg_res) ? t2_r - lg_res : '0;
  assign it_arg  = {32'b0, mul_rsp.p[127:32]} + {64'b0, t2_r};
  assign it_a    = (it_arg[63:0] == '0) ? 64'd1 : it_arg[63:0];
  assign it_d    = (cs_q > x_r) ? cs_q - x_r : x_r - cs_q;
  assign fmt_r2  = res_r >> SH_L;
  assign fmt_bad = sat_r || (st_r == ST_INVALID) || ((fmt_r2 >> (48 - SH_R)) != '0);

  hff_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_r),
    .rsp   (mul_rsp)
  );

  hff_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_r),
    .rsp   (div_rsp)
  );

  // Configuration writes are taken in any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kappa_r <= VON_KARMAN_RST;
      visc_r  <= VISCOSITY_RST;
      grav_r  <= GRAVITY_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_VON_KARMAN: kappa_r <= cfg_data;
        REG_VISCOSITY:  visc_r  <= cfg_data;
        REG_GRAVITY:    grav_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_st_r;

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    lg_ret_nxt    = lg_ret_r;
    cs_ret_nxt    = cs_ret_r;
    mul_nxt       = mul_r;
    mul_nxt.start = 1'b0;
    div_nxt       = div_r;
    div_nxt.start = 1'b0;
    act_nxt       = act_r;
    k_nxt         = k_r;
    u_nxt         = u_r;
    h_nxt         = h_r;
    st_nxt        = st_r;
    sat_nxt       = sat_r;
    res_nxt       = res_r;
    x_nxt         = x_r;
    t1_nxt        = t1_r;
    t2_nxt        = t2_r;
    re_nxt        = re_r;
    w_nxt         = w_r;
    pass_nxt      = pass_r;
    lg_n_nxt      = lg_n_r;
    lg_lz_nxt     = lg_lz_r;
    lg_e_nxt      = lg_e_r;
    lg_m_nxt      = lg_m_r;
    lg_f_nxt      = lg_f_r;
    lg_i_nxt      = lg_i_r;
    cb_root_nxt   = cb_root_r;
    cb_c2hi_nxt   = cb_c2hi_r;
    cb_lo_nxt     = cb_lo_r;
    cb_b_nxt      = cb_b_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_st_nxt    = out_st_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          act_nxt   = in_tuser;
          k_nxt     = to_int(in_tdata[47:0]);
          u_nxt     = to_int(in_tdata[95:48]);
          h_nxt     = to_int(in_tdata[143:96]);
          st_nxt    = ST_OK;
          sat_nxt   = 1'b0;
          res_nxt   = '0;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (act_r)
          ACT_COLEBROOK: begin
            if (vk_int == '0) begin
              st_nxt    = ST_INVALID;
              state_nxt = S_DONE;
            end else begin
              mul_nxt   = mreq(u_r, h_r);
              ret_nxt   = S_CW1;
              state_nxt = S_WMUL;
            end
          end
          ACT_NIKURADSE: begin
            if (k_r == '0 || h_r == '0) begin
              st_nxt    = ST_INVALID;
              state_nxt = S_DONE;
            end else begin
              lg_n_nxt   = {64'b0, k_r} + ({64'b0, h_r} << 3) + ({64'b0, h_r} << 2);
              lg_lz_nxt  = '0;
              lg_ret_nxt = S_NK1;
              state_nxt  = S_LG_NORM;
            end
          end
          ACT_MANNING: begin
            if (h_r == '0) begin
              st_nxt    = ST_INVALID;
              state_nxt = S_DONE;
            end else begin
              cb_root_nxt = '0;
              cb_b_nxt    = 6'd42;
              state_nxt   = S_CB0;
            end
          end
          default: begin
            if (k_r == '0) begin
              st_nxt    = ST_INVALID;
              state_nxt = S_DONE;
            end else begin
              mul_nxt   = mreq(k_r, k_r);
              ret_nxt   = S_CZ1;
              state_nxt = S_WMUL;
            end
          end
        endcase
      end
      S_WMUL: begin
        if (mul_rsp.done) begin
          state_nxt = ret_r;
        end
      end
      S_WDIV: begin
        if (div_rsp.done) begin
          state_nxt = ret_r;
        end
      end

      // Base-two logarithm: normalise, then one squaring per fraction bit.
      S_LG_NORM: begin
        if (lg_n_r[127]) begin
          lg_m_nxt  = {1'b0, lg_n_r[127:65]};
          lg_e_nxt  = 7'd127 - lg_lz_r;
          lg_f_nxt  = '0;
          lg_i_nxt  = '0;
          state_nxt = S_LG_SQ;
        end else if (lg_n_r[127:120] == '0) begin
          lg_n_nxt  = lg_n_r << 8;
          lg_lz_nxt = lg_lz_r + 7'd8;
        end else begin
          lg_n_nxt  = lg_n_r << 1;
          lg_lz_nxt = lg_lz_r + 7'd1;
        end
      end
      S_LG_SQ: begin
        mul_nxt   = mreq(lg_m_r, lg_m_r);
        ret_nxt   = S_LG_SQ2;
        state_nxt = S_WMUL;
      end
      S_LG_SQ2: begin
        lg_f_nxt = {lg_f_r[30:0], lg_sq[63]};
        lg_m_nxt = lg_sq[63] ? (lg_sq >> 1) : lg_sq;
        lg_i_nxt = lg_i_r + 5'd1;
        if (lg_i_r == 5'd31) begin
          state_nxt = lg_ret_r;
        end else begin
          state_nxt = S_LG_SQ;
        end
      end

      // One Colebrook-White step: x = -2.03 * log10(arg), result in cs_q.
      S_CS1: begin
        mul_nxt   = mreq(cs_neg, CW_SLOPE);
        ret_nxt   = S_CS2;
        state_nxt = S_WMUL;
      end
      S_CS2: begin
        // The product stays below 2^76, so dividing it by 100 * 2^32 is the
        // same as dividing its integer part, below 2^44, by 100.
        mul_nxt   = mreq(mul_rsp.p[95:32], CS_RECIP);
        ret_nxt   = S_CS3;
        state_nxt = S_WMUL;
      end
      S_CS3: begin
        state_nxt = cs_ret_r;
      end

      // Chezy
      S_CZ1: begin
        div_nxt   = dreq({64'b0, g_int}, mul_rsp.p, 7'd64);
        ret_nxt   = S_CZ2;
        state_nxt = S_WDIV;
      end
      S_CZ2: begin
        res_nxt   = div_rsp.q;
        sat_nxt   = sat_r | div_rsp.sat;
        state_nxt = S_DONE;
      end

      // Manning: cube root of the depth, one bit per round.
      S_CB0: begin
        mul_nxt   = mreq(cb_c, cb_c);
        ret_nxt   = S_CB1;
        state_nxt = S_WMUL;
      end
      S_CB1: begin
        cb_c2hi_nxt = mul_rsp.p[127:64];
        mul_nxt     = mreq(mul_rsp.p[63:0], cb_c);
        ret_nxt     = S_CB2;
        state_nxt   = S_WMUL;
      end
      S_CB2: begin
        cb_lo_nxt = mul_rsp.p;
        mul_nxt   = mreq(cb_c2hi_r, cb_c);
        ret_nxt   = S_CB3;
        state_nxt = S_WMUL;
      end
      S_CB3: begin
        if (cb_ok) begin
          cb_root_nxt = cb_c;
        end
        if (cb_b_r == '0) begin
          state_nxt = S_MN1;
        end else begin
          cb_b_nxt  = cb_b_r - 6'd1;
          state_nxt = S_CB0;
        end
      end
      S_MN1: begin
        mul_nxt   = mreq(g_int, k_r);
        ret_nxt   = S_MN2;
        state_nxt = S_WMUL;
      end
      S_MN2: begin
        div_nxt   = dreq(mul_rsp.p, {64'b0, cb_root_r}, 7'd0);
        ret_nxt   = S_MN3;
        state_nxt = S_WDIV;
      end
      S_MN3: begin
        sat_nxt   = sat_r | div_rsp.sat;
        mul_nxt   = mreq(div_rsp.q, k_r);
        ret_nxt   = S_MN4;
        state_nxt = S_WMUL;
      end
      S_MN4: begin
        if (mul_rsp.p[127:96] != '0) begin
          sat_nxt = 1'b1;
        end else begin
          res_nxt = mul_rsp.p[95:32];
        end
        state_nxt = S_DONE;
      end

      // Nikuradse
      S_NK1: begin
        t2_nxt     = lg_res;
        lg_n_nxt   = {64'b0, k_r};
        lg_lz_nxt  = '0;
        lg_ret_nxt = S_NK2;
        state_nxt  = S_LG_NORM;
      end
      S_NK2: begin
        mul_nxt   = mreq(nk_diff, LN2_Q32);
        ret_nxt   = S_NK3;
        state_nxt = S_WMUL;
      end
      S_NK3: begin
        t1_nxt = mul_rsp.p[95:32];
        if (mul_rsp.p[95:32] == '0) begin
          st_nxt    = ST_INVALID;
          state_nxt = S_DONE;
        end else begin
          mul_nxt   = mreq(ka_int, ka_int);
          ret_nxt   = S_NK4;
          state_nxt = S_WMUL;
        end
      end
      S_NK4: begin
        w_nxt     = mul_rsp.p;
        mul_nxt   = mreq(t1_r, t1_r);
        ret_nxt   = S_NK5;
        state_nxt = S_WMUL;
      end
      S_NK5: begin
        div_nxt   = dreq(w_r, mul_rsp.p, 7'd32);
        ret_nxt   = S_NK6;
        state_nxt = S_WDIV;
      end
      S_NK6: begin
        res_nxt   = div_rsp.q;
        sat_nxt   = sat_r | div_rsp.sat;
        state_nxt = S_DONE;
      end

      // Colebrook-White: Reynolds number first.
      S_CW1: begin
        if (mul_rsp.p[127:126] != '0) begin
          re_nxt    = '1;
          state_nxt = S_CW3;
        end else begin
          div_nxt   = dreq({mul_rsp.p[125:0], 2'b0}, {64'b0, vk_int}, 7'd0);
          ret_nxt   = S_CW2;
          state_nxt = S_WDIV;
        end
      end
      S_CW2: begin
        re_nxt    = div_rsp.q;
        state_nxt = S_CW3;
      end
      S_CW3: begin
        if (re_r <= RE_HIGH) begin
          if (re_r > RE_LOW) begin
            div_nxt   = dreq(128'd8, {64'b0, re_r}, 7'd64);
            ret_nxt   = S_LAM;
            state_nxt = S_WDIV;
          end else begin
            res_nxt   = POINT08;
            state_nxt = S_DONE;
          end
        end else begin
          mul_nxt   = mreq(64'd5, re_r);
          ret_nxt   = S_CW4;
          state_nxt = S_WMUL;
        end
      end
      S_LAM: begin
        res_nxt   = div_rsp.q;
        state_nxt = S_DONE;
      end
      S_CW4: begin
        div_nxt   = dreq({64'b0, 64'd22 << 32}, mul_rsp.p, 7'd64);
        ret_nxt   = S_CW5;
        state_nxt = S_WDIV;
      end
      S_CW5: begin
        t1_nxt    = div_rsp.q;
        mul_nxt   = mreq(64'd371, h_r);
        ret_nxt   = S_CW6;
        state_nxt = S_WMUL;
      end
      S_CW6: begin
        w_nxt     = mul_rsp.p;
        mul_nxt   = mreq(64'd25, k_r);
        ret_nxt   = S_CW7;
        state_nxt = S_WMUL;
      end
      S_CW7: begin
        div_nxt   = dreq(mul_rsp.p, w_r + mul_rsp.p, 7'd64);
        ret_nxt   = S_CW8;
        state_nxt = S_WDIV;
      end
      S_CW8: begin
        t2_nxt    = div_rsp.q;
        x_nxt     = X_START;
        pass_nxt  = '0;
        state_nxt = S_IT;
      end
      S_IT: begin
        mul_nxt   = mreq(x_r, t1_r);
        ret_nxt   = S_IT1;
        state_nxt = S_WMUL;
      end
      S_IT1: begin
        if (it_arg[127:64] != '0) begin
          st_nxt    = ST_INVALID;
          state_nxt = S_DONE;
        end else begin
          lg_n_nxt   = {64'b0, it_a};
          lg_lz_nxt  = '0;
          lg_ret_nxt = S_CS1;
          cs_ret_nxt = S_IT2;
          state_nxt  = S_LG_NORM;
        end
      end
      S_IT2: begin
        x_nxt     = cs_q;
        mul_nxt   = mreq(it_d, CONV_TOL);
        ret_nxt   = S_IT3;
        state_nxt = S_WMUL;
      end
      S_IT3: begin
        if (mul_rsp.p[63:0] <= x_r) begin
          state_nxt = S_FINX;
        end else if (pass_r == PASS_W'(MAX_ITERATIONS - 1)) begin
          // No convergence: fall back to the fully rough wall term.
          st_nxt = ST_FALLBACK;
          if (t2_r == '0) begin
            res_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            lg_n_nxt   = {64'b0, t2_r};
            lg_lz_nxt  = '0;
            lg_ret_nxt = S_CS1;
            cs_ret_nxt = S_FB2;
            state_nxt  = S_LG_NORM;
          end
        end else begin
          pass_nxt  = pass_r + PASS_W'(1);
          state_nxt = S_IT;
        end
      end
      S_FB2: begin
        x_nxt     = cs_q;
        state_nxt = S_FINX;
      end
      S_FINX: begin
        if (x_r == '0) begin
          st_nxt    = ST_INVALID;
          state_nxt = S_DONE;
        end else begin
          mul_nxt   = mreq(x_r, x_r);
          ret_nxt   = S_F1;
          state_nxt = S_WMUL;
        end
      end
      S_F1: begin
        div_nxt   = dreq(128'd1 << 93, mul_rsp.p, 7'd0);
        ret_nxt   = S_F2;
        state_nxt = S_WDIV;
      end
      S_F2: begin
        res_nxt = div_rsp.q;
        if (div_rsp.sat) begin
          st_nxt = ST_INVALID;
        end
        state_nxt = S_DONE;
      end

      // Scale to the external format and wait for the output register.
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          if (fmt_bad) begin
            out_data_nxt = '1;
            out_st_nxt   = ST_INVALID;
          end else begin
            out_data_nxt = 48'(fmt_r2 << SH_R);
            out_st_nxt   = st_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      lg_ret_r    <= S_IDLE;
      cs_ret_r    <= S_IDLE;
      mul_r       <= '0;
      div_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      lg_ret_r    <= lg_ret_nxt;
      cs_ret_r    <= cs_ret_nxt;
      mul_r       <= mul_nxt;
      div_r       <= div_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    k_r        <= k_nxt;
    u_r        <= u_nxt;
    h_r        <= h_nxt;
    st_r       <= st_nxt;
    sat_r      <= sat_nxt;
    res_r      <= res_nxt;
    x_r        <= x_nxt;
    t1_r       <= t1_nxt;
    t2_r       <= t2_nxt;
    re_r       <= re_nxt;
    w_r        <= w_nxt;
    pass_r     <= pass_nxt;
    lg_n_r     <= lg_n_nxt;
    lg_lz_r    <= lg_lz_nxt;
    lg_e_r     <= lg_e_nxt;
    lg_m_r     <= lg_m_nxt;
    lg_f_r     <= lg_f_nxt;
    lg_i_r     <= lg_i_nxt;
    cb_root_r  <= cb_root_nxt;
    cb_c2hi_r  <= cb_c2hi_nxt;
    cb_lo_r    <= cb_lo_nxt;
    cb_b_r     <= cb_b_nxt;
    out_data_r <= out_data_nxt;
    out_st_r   <= out_st_nxt;
  end

  // Every product and quotient is collected by the matching wait state.
  a_mul_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    mul_rsp.done |-> state_r == S_WMUL)
    else $error("multiplier finished while the sequencer was not waiting");

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_WDIV)
    else $error("divider finished while the sequencer was not waiting");

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while one is in progress");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK || out_tuser == ST_FALLBACK ||
                    out_tuser == ST_INVALID))
    else $error("undefined result status");

  a_invalid_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_INVALID |-> out_tdata == '1)
    else $error("invalid result not saturated");

endmodule

>>> sim/hff_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hff_checker
// Watches the channels of the friction block, predicts and compares results.
// ----------------------------------------------------------------------------
// Every accepted request is run through a bit-exact model of the friction laws
// with the configuration seen on the cfg_ channel. The predicted coefficient
// and status wait in order until the block hands out its next result.
// ----------------------------------------------------------------------------
module hff_checker
  import hff_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [143:0] in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [47:0]  out_tdata,
  input  logic [1:0]   out_tuser,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [47:0]  cfg_data,
  output int           fail_count,
  output int           pending
);

  localparam int FB = FRAC_BITS_DEF;
  localparam int ITER = MAX_ITER_DEF;
  localparam logic [63:0] MASK48 = 64'hFFFF_FFFF_FFFF;
  localparam logic [63:0] LOG10_2 = 64'd1292913986;
  localparam logic [63:0] LN2 = 64'd2977044472;
  localparam logic [63:0] POINT08 = 64'd343597384;

  typedef struct packed {
    logic [47:0] coef;
    logic [1:0]  status;
  } friction_t;

  friction_t   coef_q[$];
  logic [47:0] kappa, visc, grav;

  function automatic logic [127:0] mul(input logic [63:0] a, input logic [63:0] b);
    return {64'b0, a} * {64'b0, b};
  endfunction

  // Restoring division, floor(n * 2^shift / d), saturating like the hardware.
  function automatic logic [63:0] div_q(input logic [127:0] n, input logic [127:0] d,
                                        input int shift, inout logic sat);
    logic [127:0] r;
    logic [63:0]  q;
    logic         carry, nb;
    int           i;
    if (d == 0) begin
      sat = 1'b1;
      return '1;
    end
    r = '0;
    q = '0;
    for (i = 0; i < 128 + shift; i++) begin
      carry = r[127];
      nb = (i < 128) ? n[127 - i] : 1'b0;
      r = {r[126:0], nb};
      if (q[63]) sat = 1'b1;
      q = q << 1;
      if (carry || r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
    end
    return sat ? '1 : q;
  endfunction

  // log2 with 32 fraction bits by repeated squaring of the mantissa.
  function automatic logic [63:0] log2_q(input logic [127:0] n);
    int           e, i;
    logic [63:0]  m, f;
    logic [127:0] sq;
    e = 0;
    for (i = 0; i < 128; i++) if (n[i]) e = i;
    if (e >= 62) m = 64'(n >> (e - 62));
    else m = n[63:0] << (62 - e);
    f = '0;
    for (i = 0; i < 32; i++) begin
      sq = mul(m, m);
      m = sq[125:62];
      f = f << 1;
      if (m[63]) begin
        f[0] = 1'b1;
        m = m >> 1;
      end
    end
    return (64'(e) << 32) | f;
  endfunction

  function automatic logic [63:0] cube_root(input logic [63:0] h);
    logic [63:0]  r, c;
    logic [191:0] c3;
    int           b;
    r = '0;
    for (b = 42; b >= 0; b--) begin
      c = r | (64'd1 << b);
      c3 = {128'b0, c} * {128'b0, c} * {128'b0, c};
      if (c3[191:128] == 0 && c3[127:0] <= {h, 64'b0}) r = c;
    end
    return r;
  endfunction

  function automatic logic [63:0] to_q32(input logic [47:0] v);
    if (FB >= 32) return 64'(v) >> (FB - 32);
    return 64'(v) << (32 - FB);
  endfunction

  // x = -2.03 * log10(a / 2^64)
  function automatic logic [63:0] cw_term(input logic [63:0] a);
    logic        s;
    logic [63:0] neg;
    s = 1'b0;
    neg = (64'd64 << 32) - log2_q({64'b0, a});
    return div_q(mul(neg, 64'd203 * LOG10_2), {64'b0, 64'd100 << 32}, 0, s);
  endfunction

  function automatic logic [63:0] colebrook(input logic [63:0] k, input logic [63:0] u,
                                            input logic [63:0] h, inout logic [1:0] st);
    logic         s, conv;
    logic [63:0]  vk, re, t1, t2, x, nx, d, dm;
    logic [127:0] p, den, arg;
    int           pass;
    s = 1'b0;
    conv = 1'b0;
    x = 64'd5 << 31;
    vk = to_q32(visc);
    if (vk == 0) begin
      st = ST_INVALID;
      return '1;
    end
    p = mul(u, h);
    if (p[127:126] != 0) re = '1;
    else re = div_q(p << 2, {64'b0, vk}, 0, s);
    if (re <= (64'd500 << 32)) begin
      if (re > (64'd100 << 32)) begin
        s = 1'b0;
        return div_q(128'd8, {64'b0, re}, 64, s);
      end
      return POINT08;
    end
    s = 1'b0;
    t1 = div_q({64'b0, 64'd22 << 32}, mul(64'd5, re), 64, s);
    den = mul(64'd371, h) + mul(64'd25, k);
    t2 = div_q(mul(64'd25, k), den, 64, s);
    for (pass = 0; pass < ITER; pass++) begin
      arg = (mul(x, t1) >> 32) + {64'b0, t2};
      if (arg[127:64] != 0) begin
        st = ST_INVALID;
        return '1;
      end
      if (arg[63:0] == 0) arg[63:0] = 64'd1;
      nx = cw_term(arg[63:0]);
      d = (nx > x) ? nx - x : x - nx;
      x = nx;
      dm = d * 64'd1000000;  // wraps at 64 bits, as the hardware does
      if (dm <= x) begin
        conv = 1'b1;
        break;
      end
    end
    if (!conv) begin
      st = ST_FALLBACK;
      if (t2 == 0) return '0;
      x = cw_term(t2);
    end
    if (x == 0) begin
      st = ST_INVALID;
      return '1;
    end
    s = 1'b0;
    x = div_q({64'd1 << 29, 64'b0}, mul(x, x), 0, s);
    if (s) st = ST_INVALID;
    return x;
  endfunction

  function automatic friction_t friction(input logic [1:0] action, input logic [143:0] data);
    logic [63:0]  k, u, h, g, r, ka, la, lb, ln, q;
    logic [127:0] pr;
    logic [1:0]   st;
    logic         s;
    friction_t    res;
    k = to_q32(data[47:0]);
    u = to_q32(data[95:48]);
    h = to_q32(data[143:96]);
    g = to_q32(grav);
    r = '0;
    st = ST_OK;
    s = 1'b0;
    case (action)
      ACT_COLEBROOK: r = colebrook(k, u, h, st);
      ACT_NIKURADSE: begin
        if (k == 0 || h == 0) st = ST_INVALID;
        else begin
          ka = to_q32(kappa);
          la = log2_q({64'b0, k} + mul(64'd12, h));
          lb = log2_q({64'b0, k});
          pr = mul((la > lb) ? la - lb : 64'd0, LN2);
          ln = pr[95:32];
          if (ln == 0) st = ST_INVALID;
          else r = div_q(mul(ka, ka), mul(ln, ln), 32, s);
        end
      end
      ACT_MANNING: begin
        if (h == 0) st = ST_INVALID;
        else begin
          q = div_q(mul(g, k), {64'b0, cube_root(h)}, 0, s);
          pr = mul(q, k);
          if (s || pr[127:96] != 0) s = 1'b1;
          else r = pr[95:32];
        end
      end
      default: begin
        if (k == 0) st = ST_INVALID;
        else r = div_q({64'b0, g}, mul(k, k), 64, s);
      end
    endcase
    if (s || st == ST_INVALID) begin
      st = ST_INVALID;
      r = MASK48;
    end else if (FB >= 32) begin
      if (r > (MASK48 >> (FB - 32))) begin
        st = ST_INVALID;
        r = MASK48;
      end else r = r << (FB - 32);
    end else begin
      r = r >> (32 - FB);
      if (r > MASK48) begin
        st = ST_INVALID;
        r = MASK48;
      end
    end
    res.coef = r[47:0];
    res.status = st;
    return res;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
    kappa = VON_KARMAN_RST;
    visc = VISCOSITY_RST;
    grav = GRAVITY_RST;
  end

  always @(posedge clk) begin
    friction_t want;
    if (!rst_n) begin
      kappa <= VON_KARMAN_RST;
      visc <= VISCOSITY_RST;
      grav <= GRAVITY_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_VON_KARMAN: kappa <= cfg_data;
          REG_VISCOSITY:  visc <= cfg_data;
          REG_GRAVITY:    grav <= cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) coef_q.push_back(friction(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        if (coef_q.size() == 0) begin
          $error("unexpected result: coefficient %h status %0d", out_tdata, out_tuser);
          fail_count++;
        end else begin
          want = coef_q.pop_front();
          if (out_tdata !== want.coef) begin
            $error("coefficient: expected %h, actual %h", want.coef, out_tdata);
            fail_count++;
          end
          if (out_tuser !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_tuser);
            fail_count++;
          end
        end
      end
      pending = coef_q.size();
    end
  end

endmodule

>>> sim/hydraulic_friction_factor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hydraulic_friction_factor_tb
// Stimulus and verdict for the hydraulic friction coefficient block.
// ----------------------------------------------------------------------------
// A directed set of requests covers every law and the edge cases, then random
// requests, mostly physically plausible with some raw noise, run through
// several configuration settings and idling patterns. The checker beside the
// block predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module hydraulic_friction_factor_tb;
  import hff_pkg::*;

  // Cycles without any handshake before the run is declared hung. The
  // slowest request is Colebrook-White with every pass used.
  localparam int STALL_LIMIT = 200000;
  localparam int PHASE_ITEMS = 150;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid, in_tready;
  logic [143:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid, out_tready;
  logic [47:0]  out_tdata;
  logic [1:0]   out_tuser;
  logic         cfg_valid, cfg_ready;
  logic [1:0]   cfg_index;
  logic [47:0]  cfg_data;
  int           fail_count, pending;
  int           send_idle_pct, recv_stall_pct;
  int           quiet_cycles;

  hydraulic_friction_factor dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  hff_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver decides afresh on every falling edge whether it stalls.
  always @(negedge clk) out_tready <= ($urandom_range(99) >= recv_stall_pct);

  // The watchdog is cleared by any handshake on any of the three channels.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // A random 48-bit value scaled down by a random shift, so that magnitudes
  // spread evenly over many octaves.
  function automatic logic [47:0] spread(input int lo_sh, input int hi_sh);
    logic [47:0] v;
    v = 48'({$urandom, $urandom});
    return v >> $urandom_range(hi_sh, lo_sh);
  endfunction

  function automatic logic [47:0] any48();
    return 48'({$urandom, $urandom});
  endfunction

  // One request: optional idle cycles first, then held until it is taken.
  task automatic send_request(input logic [1:0] action, input logic [47:0] k,
                              input logic [47:0] u, input logic [47:0] h);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= action;
    in_tdata <= {h, u, k};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
    @(negedge clk);
    in_tvalid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Lower valid and wait until every predicted result has come back.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_request();
    logic [1:0] action;
    action = 2'($urandom_range(3));
    if ($urandom_range(99) < 15) send_request(action, any48(), any48(), any48());
    else begin
      case (action)
        ACT_COLEBROOK: send_request(action, spread(16, 47), spread(12, 40), spread(12, 40));
        ACT_NIKURADSE: send_request(action, spread(16, 40), any48(), spread(12, 40));
        ACT_MANNING:   send_request(action, spread(19, 28), any48(), spread(12, 40));
        default:       send_request(action, spread(8, 16), any48(), spread(12, 40));
      endcase
    end
  endtask

  initial begin
    int ph, i;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = ACT_COLEBROOK;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_VON_KARMAN;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    quiet_cycles = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed requests under the reset configuration: a 1 m/s, 1 m deep channel
    // for each law, 1 mm rough for Colebrook-White and Nikuradse; then the corners.
    send_request(ACT_COLEBROOK, 48'd4294967, 48'd1 << 32, 48'd1 << 32);
    send_request(ACT_NIKURADSE, 48'd4294967, 48'd1 << 32, 48'd1 << 32);
    send_request(ACT_MANNING, 48'd128849019, 48'd1 << 32, 48'd1 << 32);
    send_request(ACT_CHEZY, 48'd50 << 32, 48'd1 << 32, 48'd1 << 32);
    // Creeping flow of Colebrook-White.
    send_request(ACT_COLEBROOK, 48'd4294967, 48'd429497, 48'd2147484);
    send_request(ACT_COLEBROOK, 48'd4294967, 48'd4295, 48'd4295);
    send_request(ACT_COLEBROOK, 48'd4294967, 48'd0, 48'd1 << 32);
    // Smooth wall, a vanishing log argument, zero depth and all ones.
    send_request(ACT_COLEBROOK, 48'd0, 48'd1 << 32, 48'd1 << 32);
    send_request(ACT_COLEBROOK, 48'd0, '1, '1);
    send_request(ACT_COLEBROOK, 48'd4294967, 48'd1 << 32, 48'd0);
    send_request(ACT_COLEBROOK, '1, '1, '1);
    send_request(ACT_COLEBROOK, '1, 48'd1 << 32, 48'd1);
    // Nikuradse with zero roughness, zero depth and a vanishing logarithm.
    send_request(ACT_NIKURADSE, 48'd0, 48'd0, 48'd1 << 32);
    send_request(ACT_NIKURADSE, 48'd4294967, 48'd0, 48'd0);
    send_request(ACT_NIKURADSE, '1, '1, 48'd1);
    send_request(ACT_NIKURADSE, 48'd1, 48'd0, '1);
    // Manning with zero depth and extremes; Chezy with zero C and extremes.
    send_request(ACT_MANNING, 48'd128849019, 48'd0, 48'd0);
    send_request(ACT_MANNING, '1, '1, 48'd1);
    send_request(ACT_MANNING, 48'd1, 48'd0, '1);
    send_request(ACT_CHEZY, 48'd0, 48'd0, 48'd1 << 32);
    send_request(ACT_CHEZY, 48'd1, '1, '1);
    send_request(ACT_CHEZY, '1, 48'd0, 48'd0);

    for (ph = 0; ph < 5; ph++) begin
      drain();
      // The block is idle now, so the registers may be rewritten.
      case (ph)
        1: begin
          write_reg(REG_VON_KARMAN, 48'd0);
          write_reg(REG_VISCOSITY, '1);
          write_reg(REG_GRAVITY, '1);
        end
        2: begin
          write_reg(REG_VON_KARMAN, '1);
          write_reg(REG_VISCOSITY, 48'd0);
          write_reg(REG_GRAVITY, 48'd0);
        end
        3: begin
          write_reg(REG_VON_KARMAN, VON_KARMAN_RST + 48'($urandom_range(1 << 28)));
          write_reg(REG_VISCOSITY, 48'd1);
          write_reg(REG_GRAVITY, 48'd1);
        end
        4: begin
          write_reg(REG_VON_KARMAN, VON_KARMAN_RST);
          write_reg(REG_VISCOSITY, VISCOSITY_RST + 48'($urandom_range(2000)));
          write_reg(REG_GRAVITY, GRAVITY_RST - 48'($urandom_range(1 << 30)));
        end
        default: ;
      endcase
      case (ph)
        1: begin send_idle_pct = 57; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 57; end
        3: begin send_idle_pct = 8; recv_stall_pct = 8; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (i = 0; i < PHASE_ITEMS; i++) random_request();
    end

    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> filelist.f
rtl/hff_pkg.sv
rtl/hff_mul.sv
rtl/hff_div.sv
rtl/hydraulic_friction_factor.sv
sim/hff_checker.sv
sim/hydraulic_friction_factor_tb.sv
